[sv/tspcr_pkg.sv]
// ----------------------------------------------------------------------------
// tspcr_pkg
// Shared types and constants of the transport stream PCR extractor.
// ----------------------------------------------------------------------------
package tspcr_pkg;

    // one transport stream byte with its packet start mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_first;
    } ts_in_t;

    // one per-packet result
    typedef struct packed {
        logic [1:0]  status;
        logic [12:0] pid;
        logic [32:0] pcr_base;
    } ts_out_t;

    // input register contents handed to the parser
    typedef struct packed {
        logic   valid;
        ts_in_t item;
    } ts_stage_t;

    // result codes
    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_BAD_SYNC  = 2'd1;
    localparam logic [1:0] STATUS_NO_PCR    = 2'd2;
    localparam logic [1:0] STATUS_OTHER_PID = 2'd3;

    // adaptation field control values
    localparam logic [1:0] AFC_RESERVED = 2'd0;
    localparam logic [1:0] AFC_PAYLOAD  = 2'd1;
    localparam logic [1:0] AFC_ADAPT    = 2'd2;
    localparam logic [1:0] AFC_BOTH     = 2'd3;

    // packet byte offsets
    localparam logic [3:0] OFS_SYNC       = 4'd0;
    localparam logic [3:0] OFS_PID_HI     = 4'd1;
    localparam logic [3:0] OFS_PID_LO     = 4'd2;
    localparam logic [3:0] OFS_CTRL       = 4'd3;
    localparam logic [3:0] OFS_ADAPT_LEN  = 4'd4;
    localparam logic [3:0] OFS_FLAGS      = 4'd5;
    localparam logic [3:0] OFS_PCR_FIRST  = 4'd6;
    localparam logic [3:0] OFS_PCR_LAST   = 4'd9;
    localparam logic [3:0] OFS_LAST       = 4'd10;
    localparam logic [3:0] OFS_IDLE       = 4'd11;

    // header constants
    localparam logic [7:0] SYNC_BYTE      = 8'h47;
    localparam int         PCR_FLAG_BIT   = 4;
    localparam logic [7:0] MAX_ADAPT_LEN  = 8'd184;

endpackage

[sv/tspcr_in_stage.sv]
// ----------------------------------------------------------------------------
// tspcr_in_stage
// Input register: holds one byte request until the parser takes it.
// ----------------------------------------------------------------------------
module tspcr_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  tspcr_pkg::ts_in_t   byte_data,
    input  logic                advance,
    output tspcr_pkg::ts_stage_t stage
);

    logic                valid_reg;
    logic                valid_next;
    tspcr_pkg::ts_in_t   data_reg;
    logic                load;

    // free when empty or when the held byte moves on this cycle
    assign byte_ready = !valid_reg || advance;
    assign load       = byte_valid && byte_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= byte_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = data_reg;

endmodule

[sv/tspcr_parser.sv]
// ----------------------------------------------------------------------------
// tspcr_parser
// Header field state, PCR assembly and per-packet result logic.
// ----------------------------------------------------------------------------
module tspcr_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tspcr_pkg::ts_stage_t stage,
    input  logic                 step,
    output logic                 res_hit,
    output tspcr_pkg::ts_out_t   res_data
);

    logic [3:0]  offset_reg;
    logic [3:0]  offset_next;
    logic        sync_good_reg;
    logic        sync_good_next;
    logic [12:0] pid_reg;
    logic [12:0] pid_next;
    logic [1:0]  ctrl_reg;
    logic [1:0]  ctrl_next;
    logic [7:0]  adapt_len_reg;
    logic [7:0]  adapt_len_next;
    logic        pcr_flag_reg;
    logic        pcr_flag_next;
    logic [31:0] accum_reg;
    logic [31:0] accum_next;
    logic [12:0] latched_reg;
    logic [12:0] latched_next;

    logic [7:0]  b;
    logic        take;
    logic [3:0]  cur;
    logic [7:0]  len_plus;
    logic        pcr_present;
    logic [1:0]  status;

    assign b = stage.item.data_byte;

    // offset of the byte in the input register
    always_comb
    begin
        take = 1'b1;
        cur  = tspcr_pkg::OFS_SYNC;
        if (stage.item.packet_first)
        begin
            cur = tspcr_pkg::OFS_SYNC;
        end
        else if (offset_reg < tspcr_pkg::OFS_LAST)
        begin
            cur = offset_reg + 4'd1;
        end
        else
        begin
            take = 1'b0;
        end
    end

    assign res_hit = stage.valid && take && (cur == tspcr_pkg::OFS_LAST);

    // pcr presence from adaptation field control
    assign len_plus = adapt_len_reg + 8'd1;
    always_comb
    begin
        case (ctrl_reg)
            tspcr_pkg::AFC_RESERVED, tspcr_pkg::AFC_ADAPT:
                pcr_present = pcr_flag_reg;
            tspcr_pkg::AFC_BOTH:
                pcr_present = pcr_flag_reg &&
                              (len_plus inside {[8'd1 : tspcr_pkg::MAX_ADAPT_LEN - 8'd1]});
            default:
                pcr_present = 1'b0;
        endcase
    end

    // status decision
    always_comb
    begin
        if (!sync_good_reg)
        begin
            status = tspcr_pkg::STATUS_BAD_SYNC;
        end
        else if (!pcr_present)
        begin
            status = tspcr_pkg::STATUS_NO_PCR;
        end
        else if (latched_reg == 13'd0 || pid_reg == latched_reg)
        begin
            status = tspcr_pkg::STATUS_FOUND;
        end
        else
        begin
            status = tspcr_pkg::STATUS_OTHER_PID;
        end
    end

    assign res_data.status   = status;
    assign res_data.pid      = pid_reg;
    assign res_data.pcr_base = (status == tspcr_pkg::STATUS_FOUND) ?
                               {accum_reg, b[7]} : 33'd0;

    // next state per accepted byte
    always_comb
    begin
        offset_next    = offset_reg;
        sync_good_next = sync_good_reg;
        pid_next       = pid_reg;
        ctrl_next      = ctrl_reg;
        adapt_len_next = adapt_len_reg;
        pcr_flag_next  = pcr_flag_reg;
        accum_next     = accum_reg;
        latched_next   = latched_reg;
        if (step)
        begin
            if (!take)
            begin
                offset_next = tspcr_pkg::OFS_IDLE;
            end
            else
            begin
                offset_next = cur;
                case (cur)
                    tspcr_pkg::OFS_SYNC:
                    begin
                        sync_good_next = (b == tspcr_pkg::SYNC_BYTE);
                        pid_next       = 13'd0;
                        ctrl_next      = 2'd0;
                        adapt_len_next = 8'd0;
                        pcr_flag_next  = 1'b0;
                        accum_next     = 32'd0;
                    end
                    tspcr_pkg::OFS_PID_HI:    pid_next = {b[4:0], 8'h00};
                    tspcr_pkg::OFS_PID_LO:    pid_next = {pid_reg[12:8], b};
                    tspcr_pkg::OFS_CTRL:      ctrl_next = b[5:4];
                    tspcr_pkg::OFS_ADAPT_LEN: adapt_len_next = b;
                    tspcr_pkg::OFS_FLAGS:     pcr_flag_next = b[tspcr_pkg::PCR_FLAG_BIT];
                    tspcr_pkg::OFS_LAST:
                    begin
                        offset_next = tspcr_pkg::OFS_IDLE;
                        // learn the pcr pid on the first find
                        if (status == tspcr_pkg::STATUS_FOUND && latched_reg == 13'd0)
                        begin
                            latched_next = pid_reg;
                        end
                    end
                    default:
                    begin
                        // pcr base bytes
                        if (cur inside {[tspcr_pkg::OFS_PCR_FIRST : tspcr_pkg::OFS_PCR_LAST]})
                        begin
                            accum_next = {accum_reg[23:0], b};
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= tspcr_pkg::OFS_IDLE;
            sync_good_reg <= 1'b0;
            pid_reg       <= 13'd0;
            ctrl_reg      <= 2'd0;
            adapt_len_reg <= 8'd0;
            pcr_flag_reg  <= 1'b0;
            accum_reg     <= 32'd0;
            latched_reg   <= 13'd0;
        end
        else
        begin
            offset_reg    <= offset_next;
            sync_good_reg <= sync_good_next;
            pid_reg       <= pid_next;
            ctrl_reg      <= ctrl_next;
            adapt_len_reg <= adapt_len_next;
            pcr_flag_reg  <= pcr_flag_next;
            accum_reg     <= accum_next;
            latched_reg   <= latched_next;
        end
    end

    // a learned pcr pid never changes
    assert property (@(posedge clk) disable iff (!rst_n)
        (latched_reg != 13'd0) |=> (latched_reg == $past(latched_reg)))
        else $error("learned pcr pid changed");

    // a result only follows byte offset 9
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_hit) |-> (offset_reg == tspcr_pkg::OFS_PCR_LAST))
        else $error("result outside byte offset 10");

    // parser returns to idle after a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_hit) |=> (offset_reg == tspcr_pkg::OFS_IDLE))
        else $error("parser not idle after result");

endmodule

[sv/tspcr_out_stage.sv]
// ----------------------------------------------------------------------------
// tspcr_out_stage
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module tspcr_out_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  tspcr_pkg::ts_out_t load_data,
    output logic               free,
    output logic               result_valid,
    input  logic               result_ready,
    output tspcr_pkg::ts_out_t result_data
);

    logic               valid_reg;
    logic               valid_next;
    tspcr_pkg::ts_out_t data_reg;

    // a slot opens when empty or when the held result leaves now
    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = data_reg;

endmodule

[sv/ts_pcr_extractor_unit.sv]
// ----------------------------------------------------------------------------
// ts_pcr_extractor_unit
// MPEG transport stream PCR extractor, one byte per cycle while results are not held up.
// ----------------------------------------------------------------------------
// Byte channel (byte_valid/byte_ready/byte_data): one transport stream byte
// per request, packet_first set on byte offset 0 of every packet.
// Result channel (result_valid/result_ready/result_data): one request per
// packet with status, pid and the 33-bit pcr base, made when byte offset 10
// is parsed. Bytes while idle and packets cut short give no result.
// Throughput is one byte per cycle while results are not held up: a byte waits
// in the input register, the parser's header state updates as the byte leaves
// it and the result is written to the result register, which drives
// result_valid until the receiver takes the result.
// Reset clears both registers, puts the parser in idle until the next
// packet_first and forgets the learned pcr pid.
// When the receiver stalls, the held result stays put; bytes that make no
// result keep flowing, and byte_ready drops only when a second result
// would have to enter the full result register.
// ----------------------------------------------------------------------------
module ts_pcr_extractor_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  tspcr_pkg::ts_in_t  byte_data,
    output logic               result_valid,
    input  logic               result_ready,
    output tspcr_pkg::ts_out_t result_data
);

    tspcr_pkg::ts_stage_t stage;
    tspcr_pkg::ts_out_t   res_data;
    logic                 res_hit;
    logic                 out_free;
    logic                 advance;

    // held byte moves on unless its result finds the output full
    assign advance = stage.valid && (!res_hit || out_free);

    tspcr_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .advance    (advance),
        .stage      (stage)
    );

    tspcr_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .step     (advance),
        .res_hit  (res_hit),
        .res_data (res_data)
    );

    tspcr_out_stage u_out_stage
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && res_hit),
        .load_data    (res_data),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // input stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> (result_valid && !result_ready))
        else $error("byte channel stalled without result backpressure");

    // a result that was loaded appears on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_hit) |=> result_valid)
        else $error("loaded result not presented");

endmodule
